FILE: design/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Shared constants, types and state encoding for the LRU page replacement
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

    localparam int LRU_FRAMES    = 8;
    localparam int LRU_PAGE_BITS = 16;

    localparam int LRU_PAGE_W  = 16;
    localparam int LRU_SLOT_W  = 3;
    localparam int LRU_COUNT_W = 32;
    localparam int LRU_STAMP_W = 32;
    localparam int LRU_CFG_W   = 4;

    localparam logic [LRU_CFG_W-1:0]   LRU_CFG_RESET = 4'd8;
    localparam logic [LRU_COUNT_W-1:0] LRU_COUNT_MAX = '1;
    localparam logic [LRU_STAMP_W-1:0] LRU_STAMP_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic clear;
        logic check;
    } t_scan_ctl;

endpackage

`default_nettype wire

FILE: design/lru_ifs.sv
// ----------------------------------------------------------------------------
// lru_ifs
// Request, response and configuration channels of the LRU block.
// ----------------------------------------------------------------------------
`default_nettype none

interface lru_req_if;
    import lru_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [LRU_PAGE_W-1:0] page;
    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface lru_rsp_if;
    import lru_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [LRU_SLOT_W-1:0]  slot;
    logic [LRU_COUNT_W-1:0] fault_count;
    modport source (output valid, output hit, output slot, output fault_count,
                    input ready);
    modport sink   (input valid, input hit, input slot, input fault_count,
                    output ready);
endinterface

interface lru_cfg_if;
    import lru_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [LRU_CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lru_frame_mem.sv
// ----------------------------------------------------------------------------
// lru_frame_mem
// Frame page and stamp storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_frame_mem #(
    parameter int FRAMES    = lru_pkg::LRU_FRAMES,
    parameter int PAGE_BITS = lru_pkg::LRU_PAGE_BITS,
    parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [IDX_W-1:0]                i_wr_addr,
    input  wire logic [PAGE_BITS-1:0]            i_wr_page,
    input  wire logic [lru_pkg::LRU_STAMP_W-1:0] i_wr_stamp,
    input  wire logic [IDX_W-1:0]                i_rd_addr,
    output logic      [PAGE_BITS-1:0]            o_rd_page,
    output logic      [lru_pkg::LRU_STAMP_W-1:0] o_rd_stamp
);
    import lru_pkg::*;

    logic [PAGE_BITS-1:0]   r_page_mem  [FRAMES];
    logic [LRU_STAMP_W-1:0] r_stamp_mem [FRAMES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_page_mem[i_wr_addr]  <= i_wr_page;
            r_stamp_mem[i_wr_addr] <= i_wr_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_page  <= r_page_mem[i_rd_addr];
        o_rd_stamp <= r_stamp_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/lru_scan_unit.sv
// ----------------------------------------------------------------------------
// lru_scan_unit
// Shared compare unit: one frame per cycle, tracks first match, first empty
// frame and oldest stamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_scan_unit #(
    parameter int PAGE_BITS = lru_pkg::LRU_PAGE_BITS,
    parameter int IDX_W     = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lru_pkg::t_scan_ctl              i_ctl,
    input  wire logic [IDX_W-1:0]                i_idx,
    input  wire logic                            i_entry_valid,
    input  wire logic [PAGE_BITS-1:0]            i_entry_page,
    input  wire logic [lru_pkg::LRU_STAMP_W-1:0] i_entry_stamp,
    input  wire logic [PAGE_BITS-1:0]            i_key_page,
    output logic                                 o_hit,
    output logic      [IDX_W-1:0]                o_pos
);
    import lru_pkg::*;

    logic                   r_hit_found;
    logic [IDX_W-1:0]       r_hit_idx;
    logic                   r_empty_found;
    logic [IDX_W-1:0]       r_empty_idx;
    logic                   r_min_first;
    logic [LRU_STAMP_W-1:0] r_min_stamp;
    logic [IDX_W-1:0]       r_min_idx;

    logic w_match;
    logic w_older;

    assign w_match = i_entry_valid && (i_entry_page == i_key_page);
    assign w_older = r_min_first || (i_entry_stamp < r_min_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
            r_min_first   <= 1'b1;
        end else if (i_ctl.clear) begin
            r_hit_found   <= 1'b0;
            r_empty_found <= 1'b0;
            r_min_first   <= 1'b1;
        end else if (i_ctl.check) begin
            if (w_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= i_idx;
            end
            if (!i_entry_valid && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= i_idx;
            end
            if (w_older) begin
                r_min_first <= 1'b0;
                r_min_stamp <= i_entry_stamp;
                r_min_idx   <= i_idx;
            end
        end
    end

    always_comb begin
        o_hit = r_hit_found;
        priority if (r_hit_found) begin
            o_pos = r_hit_idx;
        end else if (r_empty_found) begin
            o_pos = r_empty_idx;
        end else begin
            o_pos = r_min_idx;
        end
    end

endmodule

`default_nettype wire

FILE: design/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement with use stamps, sequential frame scan.
//
//   channel   dir  payload                      handshake
//   i_req     in   page                         valid/ready
//   o_rsp     out  hit, slot, fault_count       valid/ready
//   i_cfg     in   data (frames_in_use)         valid/ready
//
// A request scans n frames, n the active frame count: one frame per
// cycle through the single memory read port and the shared compare unit,
// then a drain of the read pipeline and a write back.
// Synchronous active-low reset clears valid bits, stamp and fault counters.
// i_req is ready only when idle; one response register lets the next
// request be taken while a response waits. Write-back stalls on a full one.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = lru_pkg::LRU_FRAMES,
    parameter int PAGE_BITS = lru_pkg::LRU_PAGE_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lru_req_if.sink    i_req,
    lru_rsp_if.source  o_rsp,
    lru_cfg_if.sink    i_cfg
);
    import lru_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    t_state r_state;
    t_state n_state;

    logic [LRU_CFG_W-1:0]   r_cfg;
    logic [FRAMES-1:0]      r_valid;
    logic [PAGE_BITS-1:0]   r_page;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_chk_vld;
    logic [IDX_W-1:0]       r_chk_idx;
    logic [LRU_STAMP_W-1:0] r_stamp;
    logic [LRU_COUNT_W-1:0] r_fault;
    logic                   r_out_vld;
    logic                   r_out_hit;
    logic [LRU_SLOT_W-1:0]  r_out_slot;
    logic [LRU_COUNT_W-1:0] r_out_fault;

    logic [LRU_STAMP_W-1:0] n_stamp;
    logic [LRU_COUNT_W-1:0] n_fault;

    logic [CNT_W-1:0]       w_n;
    logic                   w_last;
    logic                   w_out_free;
    logic                   w_wr_go;
    logic                   w_hit;
    logic [IDX_W-1:0]       w_pos;
    logic [31:0]            w_page_ext;
    logic [31:0]            w_pos_ext;
    logic [PAGE_BITS-1:0]   w_rd_page;
    logic [LRU_STAMP_W-1:0] w_rd_stamp;
    t_scan_ctl              w_scan_ctl;

    always_comb begin
        priority if (r_cfg == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_cfg) > FRAMES) begin
            w_n = CNT_W'(FRAMES);
        end else begin
            w_n = CNT_W'(r_cfg);
        end
    end

    assign w_last     = (32'(r_idx) + 32'd1) == 32'(w_n);
    assign w_out_free = !r_out_vld || o_rsp.ready;
    assign w_page_ext = 32'(i_req.page);
    assign w_pos_ext  = 32'(w_pos);

    assign n_stamp = (r_stamp == LRU_STAMP_MAX) ? r_stamp : r_stamp + 1'b1;
    assign n_fault = (w_hit || r_fault == LRU_COUNT_MAX) ? r_fault : r_fault + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_req.ready      = 1'b0;
        w_scan_ctl.clear = 1'b0;
        w_scan_ctl.check = r_chk_vld;
        w_wr_go          = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready      = 1'b1;
                w_scan_ctl.clear = i_req.valid;
            end
            ST_SCAN, ST_DRAIN: begin
            end
            ST_WRITE: begin
                w_wr_go = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= LRU_CFG_RESET;
            r_valid   <= '0;
            r_chk_vld <= 1'b0;
            r_stamp   <= '0;
            r_fault   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == ST_SCAN);
            if (i_cfg.valid) begin
                r_cfg <= i_cfg.data;
            end
            if (w_wr_go) begin
                r_valid[w_pos] <= 1'b1;
                r_stamp        <= n_stamp;
                r_fault        <= n_fault;
                r_out_vld      <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (i_req.valid && i_req.ready) begin
            r_page <= w_page_ext[PAGE_BITS-1:0];
            r_idx  <= '0;
        end else if (r_state == ST_SCAN && !w_last) begin
            r_idx <= r_idx + 1'b1;
        end
        if (w_wr_go) begin
            r_out_hit   <= w_hit;
            r_out_slot  <= w_pos_ext[LRU_SLOT_W-1:0];
            r_out_fault <= n_fault;
        end
    end

    lru_frame_mem #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_go),
        .i_wr_addr  (w_pos),
        .i_wr_page  (r_page),
        .i_wr_stamp (n_stamp),
        .i_rd_addr  (r_idx),
        .o_rd_page  (w_rd_page),
        .o_rd_stamp (w_rd_stamp)
    );

    lru_scan_unit #(
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_scan_ctl),
        .i_idx         (r_chk_idx),
        .i_entry_valid (r_valid[r_chk_idx]),
        .i_entry_page  (w_rd_page),
        .i_entry_stamp (w_rd_stamp),
        .i_key_page    (r_page),
        .o_hit         (w_hit),
        .o_pos         (w_pos)
    );

    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.slot        = r_out_slot;
    assign o_rsp.fault_count = r_out_fault;

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state == ST_SCAN)
        else $error("request accepted without starting a scan");

    a_pos_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_go |-> w_pos_ext < 32'(w_n))
        else $error("frame chosen outside the active range");

    a_wr_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_go |=> o_rsp.valid && r_state == ST_IDLE)
        else $error("write-back without response");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_go && w_hit |=> $stable(r_fault))
        else $error("fault counted on a hit");

endmodule

`default_nettype wire
